// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the matrix transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ----- rtl/mbt_pkg.sv -----
// ----------------------------------------------------------------------------
// mbt_pkg
// Types and codes shared by the matrix buffer transform engine.
// ----------------------------------------------------------------------------
package mbt_pkg;

    // Commands carried by one request.
    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_READ    = 3'd1,
        ACT_SCROLL  = 3'd2,
        ACT_FLIP_V  = 3'd3,
        ACT_FLIP_H  = 3'd4,
        ACT_ROT_CW  = 3'd5,
        ACT_ROT_CCW = 3'd6,
        ACT_INVERT  = 3'd7
    } t_action;

    // Completion codes of a result.
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_RANGE   = 2'd2
    } t_status;

    // Scroll direction codes.
    localparam logic [2:0] DIR_NW = 3'd0;
    localparam logic [2:0] DIR_N  = 3'd1;
    localparam logic [2:0] DIR_NE = 3'd2;
    localparam logic [2:0] DIR_W  = 3'd3;
    localparam logic [2:0] DIR_E  = 3'd4;
    localparam logic [2:0] DIR_SW = 3'd5;
    localparam logic [2:0] DIR_S  = 3'd6;
    localparam logic [2:0] DIR_SE = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACTIVE_COLS = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_ROWS = 2'd1;
    localparam logic [1:0] CFG_INVERT_MODE = 2'd2;

    // Classified command handed from the front end to the sequencer.
    typedef struct packed {
        t_action            action;
        logic [4:0]         col;
        logic [4:0]         row;
        logic signed [15:0] value;
        logic signed [8:0]  off_x;
        logic signed [8:0]  off_y;
        t_status            status;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic signed [15:0] read_value;
        t_status            status;
    } t_result;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WRAP_X,
        ST_WRAP_Y,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/mbt_ram.sv -----
// ----------------------------------------------------------------------------
// mbt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/mbt_fifo.sv -----
// ----------------------------------------------------------------------------
// mbt_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbt_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_fifo_count, i_clk, i_rst_n, r_cnt > CW'(DEPTH), "fifo count overflow")

endmodule

// ----- rtl/mbt_front.sv -----
// ----------------------------------------------------------------------------
// mbt_front
// Accepts requests, checks coordinates and shape, and queues commands.
// ----------------------------------------------------------------------------
module mbt_front #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32,
    localparam int SW = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SW-1:0]       i_cols,
    input  logic [SW-1:0]       i_rows,
    input  logic                i_push,
    output logic                o_full,
    input  mbt_pkg::t_action    i_action,
    input  logic [4:0]          i_col,
    input  logic [4:0]          i_row,
    input  logic signed [15:0]  i_value,
    input  logic [2:0]          i_scroll_direction,
    input  logic signed [7:0]   i_scroll_steps,
    input  logic                i_cmd_pop,
    output mbt_pkg::t_cmd       o_cmd,
    output logic                o_cmd_empty
);

    mbt_pkg::t_cmd     w_cmd;
    logic signed [8:0] w_amt, w_neg;

    assign w_amt = {i_scroll_steps[7], i_scroll_steps};
    assign w_neg = -w_amt;

    // Classify the request.
    always_comb begin
        w_cmd        = '0;
        w_cmd.action = i_action;
        w_cmd.col    = i_col;
        w_cmd.row    = i_row;
        w_cmd.value  = i_value;
        w_cmd.status = mbt_pkg::STAT_DONE;

        if (i_scroll_direction inside {mbt_pkg::DIR_NW, mbt_pkg::DIR_W, mbt_pkg::DIR_SW}) begin
            w_cmd.off_x = w_neg;
        end else if (i_scroll_direction inside {mbt_pkg::DIR_N, mbt_pkg::DIR_S}) begin
            w_cmd.off_x = '0;
        end else begin
            w_cmd.off_x = w_amt;
        end
        if (i_scroll_direction inside {mbt_pkg::DIR_NW, mbt_pkg::DIR_N, mbt_pkg::DIR_NE}) begin
            w_cmd.off_y = w_neg;
        end else if (i_scroll_direction inside {mbt_pkg::DIR_W, mbt_pkg::DIR_E}) begin
            w_cmd.off_y = '0;
        end else begin
            w_cmd.off_y = w_amt;
        end

        case (i_action)
            mbt_pkg::ACT_WRITE, mbt_pkg::ACT_READ: begin
                if (32'(i_col) >= 32'(i_cols) || 32'(i_row) >= 32'(i_rows)) begin
                    w_cmd.status = mbt_pkg::STAT_RANGE;
                end
            end
            mbt_pkg::ACT_ROT_CW, mbt_pkg::ACT_ROT_CCW: begin
                if (i_cols != i_rows) begin
                    w_cmd.status = mbt_pkg::STAT_REFUSED;
                end
            end
            default: begin
                w_cmd.status = mbt_pkg::STAT_DONE;
            end
        endcase
    end

    // Command queue toward the sequencer.
    mbt_fifo #(
        .T     (mbt_pkg::t_cmd),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

// ----- rtl/mbt_back.sv -----
// ----------------------------------------------------------------------------
// mbt_back
// Sequencer that carries out commands on the matrix store element by element.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbt_back #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32,
    localparam int SW = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SW-1:0]     i_cols,
    input  logic [SW-1:0]     i_rows,
    input  logic              i_invert_mode,
    input  logic              i_cmd_empty,
    input  mbt_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output mbt_pkg::t_result  o_res
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = (SW + 1 > 9) ? SW + 1 : 9;
    localparam logic signed [17:0] INVERT_OFFSET_MV = 18'sd10000;

    mbt_pkg::t_state        r_state, n_state;
    mbt_pkg::t_cmd          r_cmd, n_cmd;
    logic [AW-1:0]          r_clr, n_clr;
    logic [SW-1:0]          r_i, n_i, r_o, n_o;
    logic [SW-1:0]          r_lim_i, n_lim_i, r_lim_o, n_lim_o;
    logic [SW-1:0]          r_off, n_off, r_ox, n_ox, r_oy, n_oy;
    logic                   r_trans, n_trans, r_sub, n_sub, r_pass, n_pass;
    logic signed [MW-1:0]   r_m, n_m;
    logic [15:0]            r_a, n_a, r_rd, n_rd;

    logic                   s_we, c_we;
    logic [AW-1:0]          s_waddr, s_raddr, c_waddr, c_raddr;
    logic [15:0]            s_wdata, c_wdata, s_rdata, c_rdata;

    logic [SW-1:0]          w_x, w_y, w_px, w_py, w_sx, w_sy, w_shift;
    logic [SW:0]            w_sum, w_i_inc, w_o_inc;
    logic                   w_scroll, w_flip, w_rot, w_i_last, w_o_last, w_last;
    logic signed [MW-1:0]   w_cols_s, w_rows_s;
    logic                   w_off_bad;

    function automatic logic [AW-1:0] at(input logic [SW-1:0] xx, input logic [SW-1:0] yy);
        at = AW'(32'(yy) * MAX_COLS + 32'(xx));
    endfunction

    function automatic logic [15:0] invert(input logic [15:0] v, input logic mode);
        logic signed [17:0] r;
        r = (mode ? INVERT_OFFSET_MV : 18'sd0) - $signed({{2{v[15]}}, v});
        if (r > 18'sd32767) begin
            invert = 16'h7FFF;
        end else if (r < -18'sd32768) begin
            invert = 16'h8000;
        end else begin
            invert = r[15:0];
        end
    endfunction

    // Element coordinates and derived addresses.
    always_comb begin
        w_scroll = (r_cmd.action == mbt_pkg::ACT_SCROLL);
        w_flip   = (r_cmd.action inside {mbt_pkg::ACT_FLIP_V, mbt_pkg::ACT_FLIP_H});
        w_rot    = (r_cmd.action inside {mbt_pkg::ACT_ROT_CW, mbt_pkg::ACT_ROT_CCW});
        w_x      = r_trans ? r_o : r_i;
        w_y      = r_trans ? r_i : r_o;
        if (r_cmd.action == mbt_pkg::ACT_FLIP_V) begin
            w_px = w_x;
            w_py = i_rows - 1'b1 - w_y;
        end else begin
            w_px = i_cols - 1'b1 - w_x;
            w_py = w_y;
        end
        if (r_cmd.action == mbt_pkg::ACT_ROT_CW) begin
            w_sx = w_y;
            w_sy = i_cols - 1'b1 - w_x;
        end else begin
            w_sx = i_cols - 1'b1 - w_y;
            w_sy = w_x;
        end
        w_sum    = {1'b0, r_i} + {1'b0, r_off};
        w_shift  = (w_sum >= {1'b0, r_lim_i}) ? SW'(w_sum - {1'b0, r_lim_i}) : SW'(w_sum);
        w_i_inc  = {1'b0, r_i} + 1'b1;
        w_o_inc  = {1'b0, r_o} + 1'b1;
        w_i_last = (w_i_inc >= {1'b0, r_lim_i});
        w_o_last = (w_o_inc >= {1'b0, r_lim_o});
        w_last   = w_i_last && (!w_scroll || r_sub) && w_o_last;
        w_cols_s = MW'($signed({1'b0, i_cols}));
        w_rows_s = MW'($signed({1'b0, i_rows}));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbt_pkg::ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = mbt_pkg::ST_IDLE;
            end
            mbt_pkg::ST_IDLE: begin
                if (!i_cmd_empty && !i_res_full) n_state = mbt_pkg::ST_START;
            end
            mbt_pkg::ST_START: begin
                if (r_cmd.status != mbt_pkg::STAT_DONE) begin
                    n_state = mbt_pkg::ST_DONE;
                end else begin
                    case (r_cmd.action)
                        mbt_pkg::ACT_WRITE:  n_state = mbt_pkg::ST_DONE;
                        mbt_pkg::ACT_READ:   n_state = mbt_pkg::ST_RD_WAIT;
                        mbt_pkg::ACT_SCROLL: n_state = mbt_pkg::ST_WRAP_X;
                        mbt_pkg::ACT_FLIP_V: begin
                            n_state = (i_rows < SW'(2)) ? mbt_pkg::ST_DONE : mbt_pkg::ST_RD_A;
                        end
                        mbt_pkg::ACT_FLIP_H: begin
                            n_state = (i_cols < SW'(2)) ? mbt_pkg::ST_DONE : mbt_pkg::ST_RD_A;
                        end
                        default:             n_state = mbt_pkg::ST_RD_A;
                    endcase
                end
            end
            mbt_pkg::ST_WRAP_X: begin
                if (r_m >= 0 && r_m < w_cols_s) n_state = mbt_pkg::ST_WRAP_Y;
            end
            mbt_pkg::ST_WRAP_Y: begin
                if (r_m >= 0 && r_m < w_rows_s) begin
                    if (r_ox != '0 || r_m != '0) n_state = mbt_pkg::ST_RD_A;
                    else n_state = mbt_pkg::ST_DONE;
                end
            end
            mbt_pkg::ST_RD_A: begin
                n_state = w_flip ? mbt_pkg::ST_RD_B : mbt_pkg::ST_WR_A;
            end
            mbt_pkg::ST_RD_B: n_state = mbt_pkg::ST_WR_A;
            mbt_pkg::ST_WR_A, mbt_pkg::ST_WR_B: begin
                if (r_state == mbt_pkg::ST_WR_A && w_flip) begin
                    n_state = mbt_pkg::ST_WR_B;
                end else if (!w_last) begin
                    n_state = mbt_pkg::ST_RD_A;
                end else if (!r_pass && ((w_scroll && r_oy != '0) || w_rot)) begin
                    n_state = mbt_pkg::ST_RD_A;
                end else begin
                    n_state = mbt_pkg::ST_DONE;
                end
            end
            mbt_pkg::ST_RD_WAIT: n_state = mbt_pkg::ST_DONE;
            mbt_pkg::ST_DONE:    n_state = mbt_pkg::ST_IDLE;
            default:             n_state = mbt_pkg::ST_IDLE;
        endcase
    end

    // Datapath registers and memory controls.
    always_comb begin
        n_cmd   = r_cmd;
        n_clr   = r_clr;
        n_i     = r_i;
        n_o     = r_o;
        n_lim_i = r_lim_i;
        n_lim_o = r_lim_o;
        n_off   = r_off;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_trans = r_trans;
        n_sub   = r_sub;
        n_pass  = r_pass;
        n_m     = r_m;
        n_a     = r_a;
        n_rd    = r_rd;
        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_raddr = '0;
        c_we    = 1'b0;
        c_waddr = '0;
        c_wdata = '0;
        c_raddr = '0;
        o_cmd_pop = 1'b0;

        case (r_state)
            mbt_pkg::ST_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
            end
            mbt_pkg::ST_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                end
            end
            mbt_pkg::ST_START: begin
                n_rd    = '0;
                n_i     = '0;
                n_o     = '0;
                n_sub   = 1'b0;
                n_pass  = 1'b0;
                n_trans = 1'b0;
                n_lim_i = i_cols;
                n_lim_o = i_rows;
                n_m     = MW'(r_cmd.off_x);
                if (r_cmd.action == mbt_pkg::ACT_FLIP_V) n_lim_o = i_rows >> 1;
                if (r_cmd.action == mbt_pkg::ACT_FLIP_H) n_lim_i = i_cols >> 1;
                s_waddr = at(SW'(r_cmd.col), SW'(r_cmd.row));
                s_raddr = at(SW'(r_cmd.col), SW'(r_cmd.row));
                s_wdata = r_cmd.value;
                s_we    = (r_cmd.action == mbt_pkg::ACT_WRITE) &&
                          (r_cmd.status == mbt_pkg::STAT_DONE);
            end
            mbt_pkg::ST_WRAP_X: begin
                // One add or subtract of the size per cycle until in range.
                if (r_m < 0) begin
                    n_m = r_m + w_cols_s;
                end else if (r_m >= w_cols_s) begin
                    n_m = r_m - w_cols_s;
                end else begin
                    n_ox = SW'(r_m);
                    n_m  = MW'(r_cmd.off_y);
                end
            end
            mbt_pkg::ST_WRAP_Y: begin
                if (r_m < 0) begin
                    n_m = r_m + w_rows_s;
                end else if (r_m >= w_rows_s) begin
                    n_m = r_m - w_rows_s;
                end else begin
                    n_oy = SW'(r_m);
                    if (r_ox != '0) begin
                        n_off = r_ox;
                    end else begin
                        n_pass  = 1'b1;
                        n_trans = 1'b1;
                        n_lim_i = i_rows;
                        n_lim_o = i_cols;
                        n_off   = SW'(r_m);
                    end
                end
            end
            mbt_pkg::ST_RD_A: begin
                s_raddr = at(w_x, w_y);
                c_raddr = w_scroll ? AW'(r_i) : at(w_sx, w_sy);
            end
            mbt_pkg::ST_RD_B: begin
                n_a     = s_rdata;
                s_raddr = at(w_px, w_py);
            end
            mbt_pkg::ST_RD_WAIT: begin
                n_rd = s_rdata;
            end
            default: begin
            end
        endcase

        // Element writes.
        if (r_state == mbt_pkg::ST_WR_A) begin
            if (r_cmd.action == mbt_pkg::ACT_INVERT) begin
                s_we    = 1'b1;
                s_waddr = at(w_x, w_y);
                s_wdata = invert(s_rdata, i_invert_mode);
            end else if (w_flip) begin
                s_we    = 1'b1;
                s_waddr = at(w_x, w_y);
                s_wdata = s_rdata;
            end else if (w_rot) begin
                if (!r_pass) begin
                    c_we    = 1'b1;
                    c_waddr = at(w_x, w_y);
                    c_wdata = s_rdata;
                end else begin
                    s_we    = 1'b1;
                    s_waddr = at(w_x, w_y);
                    s_wdata = c_rdata;
                end
            end else if (!r_sub) begin
                c_we    = 1'b1;
                c_waddr = AW'(r_i);
                c_wdata = s_rdata;
            end else begin
                s_we    = 1'b1;
                s_waddr = r_trans ? at(r_o, w_shift) : at(w_shift, r_o);
                s_wdata = c_rdata;
            end
        end
        if (r_state == mbt_pkg::ST_WR_B) begin
            s_we    = 1'b1;
            s_waddr = at(w_px, w_py);
            s_wdata = r_a;
        end

        // Loop counters advance after the last write of an element.
        if ((r_state == mbt_pkg::ST_WR_A && !w_flip) || r_state == mbt_pkg::ST_WR_B) begin
            if (!w_i_last) begin
                n_i = SW'(w_i_inc);
            end else begin
                n_i = '0;
                if (w_scroll && !r_sub) begin
                    n_sub = 1'b1;
                end else begin
                    n_sub = 1'b0;
                    if (!w_o_last) begin
                        n_o = SW'(w_o_inc);
                    end else begin
                        n_o    = '0;
                        n_pass = 1'b1;
                        if (w_scroll) begin
                            n_trans = 1'b1;
                            n_lim_i = i_rows;
                            n_lim_o = i_cols;
                            n_off   = r_oy;
                        end
                    end
                end
            end
        end
    end

    // Results.
    assign o_res_push       = (r_state == mbt_pkg::ST_DONE);
    assign o_res.read_value = r_rd;
    assign o_res.status     = r_cmd.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbt_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_i     <= n_i;
        r_o     <= n_o;
        r_lim_i <= n_lim_i;
        r_lim_o <= n_lim_o;
        r_off   <= n_off;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_trans <= n_trans;
        r_sub   <= n_sub;
        r_pass  <= n_pass;
        r_m     <= n_m;
        r_a     <= n_a;
        r_rd    <= n_rd;
    end

    // Matrix store.
    mbt_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Scratch store: line buffer for scroll, copy for rotate.
    mbt_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_scratch (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // A scroll write whose offset was not reduced below the line length.
    assign w_off_bad = (r_state == mbt_pkg::ST_WR_A) && w_scroll && r_sub && (r_off >= r_lim_i);

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, o_res_push && i_res_full, "result queue overflow")
    `ASSERT_NEVER(a_off_range, i_clk, i_rst_n, w_off_bad, "scroll offset not reduced")
    `ASSERT_CLK(a_pop_start, i_clk, i_rst_n, o_cmd_pop |=> (r_state == mbt_pkg::ST_START), "no start")

endmodule

// ----- rtl/matrix_buffer_transform_engine.sv -----
// ----------------------------------------------------------------------------
// matrix_buffer_transform_engine
// Matrix of signed samples with element access and whole-matrix transforms.
//
//   Channel   Handshake        Payload
//   input     push / full      action, col, row, value, scroll_direction,
//                              scroll_steps
//   result    pop / empty      read_value, status
//   config    i_cfg_we         i_cfg_index, i_cfg_data
//
// In the sequencer a write or refused command passes through start and done,
// and a read adds a wait for the store's registered data. Transforms visit
// elements: invert reads and writes each active element, flips read and write
// both elements of each swapped pair, rotate makes a copy pass plus a write
// pass, and scroll makes a line-buffer pass per axis with a nonzero offset after
// reducing each offset by adding or subtracting the size; the store has a single
// read and a single write port. After reset a clearing pass over all
// MAX_COLS*MAX_ROWS store entries runs before the first command starts; requests
// are queued meanwhile. Two commands and two results can wait in the queues.
// ----------------------------------------------------------------------------
module matrix_buffer_transform_engine #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_action,
    input  logic [4:0]         i_col,
    input  logic [4:0]         i_row,
    input  logic signed [15:0] i_value,
    input  logic [2:0]         i_scroll_direction,
    input  logic signed [7:0]  i_scroll_steps,
    input  logic               pop,
    output logic               empty,
    output logic signed [15:0] o_read_value,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data
);

    localparam int SW = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);

    logic [5:0]        r_active_cols, r_active_rows;
    logic              r_invert_mode;
    logic [SW-1:0]     w_cols, w_rows;
    mbt_pkg::t_cmd     w_cmd;
    logic              w_cmd_empty, w_cmd_pop;
    mbt_pkg::t_result  w_res, w_res_out;
    logic              w_res_push, w_res_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cols <= 6'd16;
            r_active_rows <= 6'd16;
            r_invert_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbt_pkg::CFG_ACTIVE_COLS: r_active_cols <= i_cfg_data;
                mbt_pkg::CFG_ACTIVE_ROWS: r_active_rows <= i_cfg_data;
                mbt_pkg::CFG_INVERT_MODE: r_invert_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Active size clamped to one through the maximum.
    always_comb begin
        if (r_active_cols == '0) w_cols = SW'(1);
        else if (32'(r_active_cols) > MAX_COLS) w_cols = SW'(MAX_COLS);
        else w_cols = SW'(r_active_cols);
        if (r_active_rows == '0) w_rows = SW'(1);
        else if (32'(r_active_rows) > MAX_ROWS) w_rows = SW'(MAX_ROWS);
        else w_rows = SW'(r_active_rows);
    end

    mbt_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cols             (w_cols),
        .i_rows             (w_rows),
        .i_push             (push),
        .o_full             (full),
        .i_action           (mbt_pkg::t_action'(i_action)),
        .i_col              (i_col),
        .i_row              (i_row),
        .i_value            (i_value),
        .i_scroll_direction (i_scroll_direction),
        .i_scroll_steps     (i_scroll_steps),
        .i_cmd_pop          (w_cmd_pop),
        .o_cmd              (w_cmd),
        .o_cmd_empty        (w_cmd_empty)
    );

    mbt_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cols        (w_cols),
        .i_rows        (w_rows),
        .i_invert_mode (r_invert_mode),
        .i_cmd_empty   (w_cmd_empty),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .i_res_full    (w_res_full),
        .o_res_push    (w_res_push),
        .o_res         (w_res)
    );

    // Result queue.
    mbt_fifo #(
        .T     (mbt_pkg::t_result),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_read_value = w_res_out.read_value;
    assign o_status     = w_res_out.status;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Matrix buffer transform engine testbench
// Drives element writes, reads and whole-matrix commands through the queue
// ports, keeps a matrix model of its own in a scoreboard, and checks every
// result field against it. Sizes and invert mode change between phases.
// ----------------------------------------------------------------------------

// Matrix predictor and store of expected results.
class matrix_scoreboard;
    logic signed [15:0] cells [0:1023];
    int unsigned        cols_reg;
    int unsigned        rows_reg;
    bit                 invert_to_10v;
    mbt_pkg::t_result   pending [$];
    int                 mismatches;

    function new();
        for (int k = 0; k < 1024; k++) begin
            cells[k] = '0;
        end
        cols_reg = 16;
        rows_reg = 16;
        invert_to_10v = 1'b1;
        mismatches = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [5:0] data);
        if (index == mbt_pkg::CFG_ACTIVE_COLS) begin
            cols_reg = data;
        end else if (index == mbt_pkg::CFG_ACTIVE_ROWS) begin
            rows_reg = data;
        end else if (index == mbt_pkg::CFG_INVERT_MODE) begin
            invert_to_10v = data[0];
        end
    endfunction

    static function int unsigned fit_size(int unsigned v);
        if (v == 0) begin
            return 1;
        end
        return (v > 32) ? 32 : v;
    endfunction

    static function int unsigned true_mod(int off, int unsigned n);
        int m;
        m = off % int'(n);
        if (m < 0) begin
            m += n;
        end
        return m;
    endfunction

    // Apply one accepted request to the model and queue its result.
    function void note_request(mbt_pkg::t_action act, logic [4:0] col, logic [4:0] row,
                               logic signed [15:0] value, logic [2:0] dir,
                               logic signed [7:0] amount);
        logic signed [15:0] copy [0:1023];
        logic signed [15:0] line [0:31];
        logic signed [15:0] tmp;
        int unsigned        nc;
        int unsigned        nr;
        int unsigned        ox;
        int unsigned        oy;
        int                 dx;
        int                 dy;
        int                 r;
        mbt_pkg::t_result   res;
        nc = fit_size(cols_reg);
        nr = fit_size(rows_reg);
        res.read_value = '0;
        res.status = mbt_pkg::STAT_DONE;
        case (act)
            mbt_pkg::ACT_WRITE, mbt_pkg::ACT_READ: begin
                if (col >= nc || row >= nr) begin
                    res.status = mbt_pkg::STAT_RANGE;
                end else if (act == mbt_pkg::ACT_WRITE) begin
                    cells[row * 32 + col] = value;
                end else begin
                    res.read_value = cells[row * 32 + col];
                end
            end
            mbt_pkg::ACT_SCROLL: begin
                dx = (dir == mbt_pkg::DIR_NW || dir == mbt_pkg::DIR_W ||
                      dir == mbt_pkg::DIR_SW) ? -1 :
                     (dir == mbt_pkg::DIR_NE || dir == mbt_pkg::DIR_E ||
                      dir == mbt_pkg::DIR_SE) ? 1 : 0;
                dy = (dir == mbt_pkg::DIR_NW || dir == mbt_pkg::DIR_N ||
                      dir == mbt_pkg::DIR_NE) ? -1 :
                     (dir == mbt_pkg::DIR_SW || dir == mbt_pkg::DIR_S ||
                      dir == mbt_pkg::DIR_SE) ? 1 : 0;
                ox = true_mod(dx * int'(amount), nc);
                oy = true_mod(dy * int'(amount), nr);
                for (int y = 0; y < nr; y++) begin
                    for (int x = 0; x < nc; x++) line[x] = cells[y * 32 + x];
                    for (int x = 0; x < nc; x++) cells[y * 32 + (x + ox) % nc] = line[x];
                end
                for (int x = 0; x < nc; x++) begin
                    for (int y = 0; y < nr; y++) line[y] = cells[y * 32 + x];
                    for (int y = 0; y < nr; y++) cells[((y + oy) % nr) * 32 + x] = line[y];
                end
            end
            mbt_pkg::ACT_FLIP_V: begin
                for (int x = 0; x < nc; x++) begin
                    for (int y = 0; y < nr / 2; y++) begin
                        tmp = cells[y * 32 + x];
                        cells[y * 32 + x] = cells[(nr - 1 - y) * 32 + x];
                        cells[(nr - 1 - y) * 32 + x] = tmp;
                    end
                end
            end
            mbt_pkg::ACT_FLIP_H: begin
                for (int y = 0; y < nr; y++) begin
                    for (int x = 0; x < nc / 2; x++) begin
                        tmp = cells[y * 32 + x];
                        cells[y * 32 + x] = cells[y * 32 + nc - 1 - x];
                        cells[y * 32 + nc - 1 - x] = tmp;
                    end
                end
            end
            mbt_pkg::ACT_ROT_CW, mbt_pkg::ACT_ROT_CCW: begin
                if (nc != nr) begin
                    res.status = mbt_pkg::STAT_REFUSED;
                end else begin
                    copy = cells;
                    for (int y = 0; y < nc; y++) begin
                        for (int x = 0; x < nc; x++) begin
                            cells[y * 32 + x] = (act == mbt_pkg::ACT_ROT_CW)
                                ? copy[(nc - 1 - x) * 32 + y]
                                : copy[x * 32 + nc - 1 - y];
                        end
                    end
                end
            end
            default: begin
                // Invert saturates to the signed 16-bit range.
                for (int y = 0; y < nr; y++) begin
                    for (int x = 0; x < nc; x++) begin
                        r = (invert_to_10v ? 10000 : 0) - int'(cells[y * 32 + x]);
                        if (r > 32767) r = 32767;
                        if (r < -32768) r = -32768;
                        cells[y * 32 + x] = r[15:0];
                    end
                end
            end
        endcase
        pending.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic signed [15:0] read_value, logic [1:0] status);
        mbt_pkg::t_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result read_value=%0d status=%0d",
                     $time, read_value, status);
            mismatches++;
            return;
        end
        want = pending.pop_front();
        if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, want.read_value, read_value);
            mismatches++;
        end
        if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [2:0]         i_action = '0;
    logic [4:0]         i_col = '0;
    logic [4:0]         i_row = '0;
    logic signed [15:0] i_value = '0;
    logic [2:0]         i_scroll_direction = '0;
    logic signed [7:0]  i_scroll_steps = '0;
    logic               pop = 1'b0;
    logic               empty;
    logic signed [15:0] o_read_value;
    logic [1:0]         o_status;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [5:0]         i_cfg_data = '0;

    matrix_scoreboard board;
    int               requests_sent;
    int               results_seen;
    int               idle_cycles;
    bit               receiver_hold;

    localparam int IDLE_LIMIT = 200000;

    matrix_buffer_transform_engine i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                board.note_request(mbt_pkg::t_action'(i_action), i_col, i_row, i_value,
                                   i_scroll_direction, i_scroll_steps);
                requests_sent <= requests_sent + 1;
            end
            if (pop && !empty) begin
                board.check_result(o_read_value, o_status);
                results_seen <= results_seen + 1;
            end
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Watchdog on cycles with no request or result accepted.
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver: random gaps between pops, or a long hold when asked.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (receiver_hold) begin
                pop <= 1'b0;
            end else if (pop && !empty) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                    pop <= 1'b1;
                end
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted.
    task automatic send_request(mbt_pkg::t_action act, logic [4:0] col, logic [4:0] row,
                                logic signed [15:0] value, logic [2:0] dir,
                                logic signed [7:0] amount, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_action <= act;
        i_col <= col;
        i_row <= row;
        i_value <= value;
        i_scroll_direction <= dir;
        i_scroll_steps <= amount;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until every result is back, then let the block settle.
    task automatic drain();
        push <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [5:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        board.set_register(index, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random command mix: mostly element traffic, some transforms.
    task automatic random_request(int unsigned nc, int unsigned nr);
        mbt_pkg::t_action act;
        logic [4:0] col;
        logic [4:0] row;
        int pick;
        pick = $urandom_range(0, 99);
        act = (pick < 35) ? mbt_pkg::ACT_WRITE : (pick < 65) ? mbt_pkg::ACT_READ
            : mbt_pkg::t_action'($urandom_range(2, 7));
        if ($urandom_range(0, 9) == 0) begin
            col = 5'($urandom);
            row = 5'($urandom);
        end else begin
            col = 5'($urandom_range(0, nc - 1));
            row = 5'($urandom_range(0, nr - 1));
        end
        send_request(act, col, row, 16'($urandom), 3'($urandom),
                     8'($urandom_range(0, 128) - 64), $urandom_range(0, 4) == 0);
    endtask

    initial begin
        int unsigned sizes [5][2] = '{'{4, 4}, '{1, 1}, '{32, 32}, '{5, 3}, '{2, 7}};
        board = new();
        idle_cycles = 0;
        requests_sent = 0;
        results_seen = 0;
        receiver_hold = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes at the reset size, each command at least once.
        send_request(mbt_pkg::ACT_WRITE, 0, 0, 16'sh7fff, mbt_pkg::DIR_NW, 0, 1);
        send_request(mbt_pkg::ACT_WRITE, 15, 15, 16'sh8000, mbt_pkg::DIR_NW, 0, 1);
        send_request(mbt_pkg::ACT_WRITE, 3, 1, -16'sd1, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_WRITE, 16, 0, 16'sd5, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_READ, 31, 31, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_READ, 15, 15, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_INVERT, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_READ, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_READ, 15, 15, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_SCROLL, 0, 0, 0, mbt_pkg::DIR_SE, 8'sd64, 0);
        send_request(mbt_pkg::ACT_SCROLL, 0, 0, 0, mbt_pkg::DIR_NW, -8'sd64, 0);
        send_request(mbt_pkg::ACT_SCROLL, 0, 0, 0, mbt_pkg::DIR_W, 8'sd17, 0);
        send_request(mbt_pkg::ACT_SCROLL, 0, 0, 0, mbt_pkg::DIR_N, -8'sd3, 0);
        send_request(mbt_pkg::ACT_FLIP_V, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_FLIP_H, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_ROT_CW, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_ROT_CCW, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_READ, 0, 15, 0, mbt_pkg::DIR_NW, 0, 0);
        drain();

        // Invert to minus v, where minus the most negative value saturates.
        write_register(mbt_pkg::CFG_INVERT_MODE, 6'd0);
        send_request(mbt_pkg::ACT_WRITE, 1, 1, 16'sh8000, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_INVERT, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_READ, 1, 1, 0, mbt_pkg::DIR_NW, 0, 0);
        drain();

        // Sizes of zero and above the maximum, and a non-square rotate.
        write_register(mbt_pkg::CFG_ACTIVE_COLS, 6'd0);
        write_register(mbt_pkg::CFG_ACTIVE_ROWS, 6'd63);
        send_request(mbt_pkg::ACT_ROT_CW, 0, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_READ, 1, 0, 0, mbt_pkg::DIR_NW, 0, 0);
        send_request(mbt_pkg::ACT_SCROLL, 0, 0, 0, mbt_pkg::DIR_S, 8'sd33, 0);
        drain();

        // Random phases over several sizes and both invert modes.
        for (int p = 0; p < 5; p++) begin
            write_register(mbt_pkg::CFG_ACTIVE_COLS, 6'(sizes[p][0]));
            write_register(mbt_pkg::CFG_ACTIVE_ROWS, 6'(sizes[p][1]));
            write_register(mbt_pkg::CFG_INVERT_MODE, 6'(p % 2));
            for (int k = 0; k < ((p == 2) ? 20 : 62); k++) begin
                random_request(sizes[p][0], sizes[p][1]);
            end
            // Long receiver hold while requests keep coming.
            if (p == 0) begin
                receiver_hold = 1'b1;
                fork
                    begin
                        repeat (300) @(negedge i_clk);
                        receiver_hold = 1'b0;
                    end
                    for (int k = 0; k < 8; k++) begin
                        send_request(mbt_pkg::ACT_READ, 5'($urandom_range(0, 3)),
                                     5'($urandom_range(0, 3)), 0, mbt_pkg::DIR_NW, 0, 1);
                    end
                join
            end
            drain();
        end

        $display("Covered %0d requests and %0d results over sizes 1x1 to 32x32,",
                 requests_sent, results_seen);
        $display("both invert modes, all commands and a receiver stall.");
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
